/* src/dbcs_pkg.sv */
// shared types and codes for the dbcs character span scanner
// no dependencies; imported by the pair cell, the result queue and the top level
package dbcs_pkg;

  // request codes carried in the input item's tuser
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_CTRL  = 2'd1;
  localparam logic [1:0] REQ_SCAN  = 2'd2;

  // widths of the item fields
  localparam int BYTE_W = 8;
  localparam int KEY_W  = 16;
  localparam int LEN_W  = 16;

  // scan phase of the string being measured
  typedef enum logic [1:0] {
    PH_SCAN = 2'd0,
    PH_LEAD = 2'd1,
    PH_SKIP = 2'd2
  } scan_phase_t;

  // control handed to every cell of the pair chain
  typedef struct packed {
    logic             shift;
    logic [KEY_W-1:0] probe;
  } pair_ctl_t;

  // one result item
  typedef struct packed {
    logic             set_overflowed;
    logic             length_saturated;
    logic [LEN_W-1:0] span_length;
  } result_t;

endpackage

/* src/dbcs_pair_cell.sv */
// one cell of the lead/trail pair chain: holds a key, passes it on when a pair is inserted
// and compares it against the probed pair; depends on dbcs_pkg
module dbcs_pair_cell
  import dbcs_pkg::*;
(
  input  logic             clk,
  input  pair_ctl_t        ctl,
  input  logic             active,
  input  logic [KEY_W-1:0] key_in,
  output logic [KEY_W-1:0] key_out,
  output logic             hit
);

  logic [KEY_W-1:0] key_r;

  // shift stage: take the neighbour's key on insertion
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key_r <= key_in;
    end
  end

  // match against the probed pair, only inside the filled part of the chain
  assign key_out = key_r;
  assign hit     = active && (key_r == ctl.probe);

endmodule

/* src/dbcs_out_fifo.sv */
// two-entry result queue between the scanner core and the output channel
// depends on dbcs_pkg
module dbcs_out_fifo
  import dbcs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    pop_valid,
  input  logic    pop_ready,
  output result_t pop_data
);

  result_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign pop_data  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/dbcs_character_span_scanner.sv */
// dbcs character span scanner: one item accepted per cycle, back to back, while in_tready
// is high; a span's result is queued and leaves on out_tvalid after older results. the pair
// chain compares all stored pairs in parallel and the member bitmap is one flip-flop per byte
// value, so each string byte is handled as accepted. in_tready falls only while both result
// queue slots are held. synchronous active-low reset clears the member bitmap, pair count,
// lead map, flags and the scan phase at once; no clearing pass follows
module dbcs_character_span_scanner
  import dbcs_pkg::*;
#(
  parameter int PAIR_DEPTH  = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // result item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] span_length, [16] length_saturated,
                                  // [17] set_overflowed, [23:18] zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int PCNT_W = $clog2(PAIR_DEPTH + 1);

  // configuration and set state
  logic [63:0]             lead_map_r [4];
  logic [255:0]            single_r, single_nxt;
  logic [PCNT_W-1:0]       pair_cnt_r, pair_cnt_nxt;
  logic                    ctl_pend_r, ctl_pend_nxt;
  logic [BYTE_W-1:0]       ctl_lead_r, ctl_lead_nxt;
  logic                    closed_r, closed_nxt;
  logic                    ovf_r, ovf_nxt;
  // scan state
  scan_phase_t             phase_r, phase_nxt;
  logic [BYTE_W-1:0]       scan_lead_r, scan_lead_nxt;
  logic [COUNT_WIDTH-1:0]  span_cnt_r, span_cnt_nxt;
  logic                    sat_r, sat_nxt;

  logic                    acc;
  logic [1:0]              req;
  logic [BYTE_W-1:0]       b;
  logic                    b_zero;
  logic                    b_lead;
  logic                    b_member;
  logic                    pair_hit;
  logic                    is_scan;

  // scan decisions
  logic                    emit;
  logic                    add1;
  logic                    add2;
  logic                    insert;

  logic [COUNT_WIDTH:0]    span_sum;
  logic                    len_clamp;
  result_t                 res;
  logic                    fifo_full;
  result_t                 out_res;

  pair_ctl_t               chain_ctl;
  logic [KEY_W-1:0]        chain_key [PAIR_DEPTH+1];
  logic [PAIR_DEPTH-1:0]   cell_hit;

  assign cfg_ready = 1'b1;
  assign in_tready = !fifo_full;
  assign acc       = in_tvalid && in_tready;
  assign req       = in_tuser;
  assign b         = in_tdata;
  assign b_zero    = (b == '0);
  assign b_lead    = lead_map_r[b[7:6]][b[5:0]];
  assign b_member  = single_r[b];
  assign pair_hit  = |cell_hit;
  assign is_scan   = acc && (req == REQ_SCAN);

  // lead map registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        lead_map_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      lead_map_r[cfg_index] <= cfg_data;
    end
  end

  // control set building
  always_comb begin
    single_nxt   = single_r;
    pair_cnt_nxt = pair_cnt_r;
    ctl_pend_nxt = ctl_pend_r;
    ctl_lead_nxt = ctl_lead_r;
    closed_nxt   = closed_r;
    ovf_nxt      = ovf_r;
    insert       = 1'b0;
    if (acc && (req == REQ_CLEAR)) begin
      single_nxt   = '0;
      pair_cnt_nxt = '0;
      ctl_pend_nxt = 1'b0;
      ctl_lead_nxt = '0;
      closed_nxt   = 1'b0;
      ovf_nxt      = 1'b0;
    end else if (acc && (req == REQ_CTRL) && !closed_r) begin
      if (ctl_pend_r) begin
        ctl_pend_nxt = 1'b0;
        if (b_zero) begin
          closed_nxt = 1'b1;
        end else if (pair_cnt_r < PCNT_W'(PAIR_DEPTH)) begin
          insert       = 1'b1;
          pair_cnt_nxt = pair_cnt_r + PCNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end else if (b_zero) begin
        closed_nxt = 1'b1;
      end else if (b_lead) begin
        ctl_pend_nxt = 1'b1;
        ctl_lead_nxt = b;
      end else begin
        single_nxt[b] = 1'b1;
      end
    end
  end

  // scan phase: next state
  always_comb begin
    phase_nxt     = phase_r;
    scan_lead_nxt = scan_lead_r;
    if (is_scan) begin
      case (phase_r)
        PH_SCAN: begin
          if (b_zero) begin
            phase_nxt = PH_SCAN;
          end else if (b_lead) begin
            phase_nxt     = PH_LEAD;
            scan_lead_nxt = b;
          end else if (!b_member) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_LEAD: begin
          if (b_zero || pair_hit) begin
            phase_nxt = PH_SCAN;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (b_zero) begin
            phase_nxt = PH_SCAN;
          end
        end
        default: begin
          phase_nxt = PH_SCAN;
        end
      endcase
    end
  end

  // scan phase: outputs (count steps and result)
  always_comb begin
    emit = 1'b0;
    add1 = 1'b0;
    add2 = 1'b0;
    if (is_scan) begin
      case (phase_r)
        PH_SCAN: begin
          if (b_zero) begin
            emit = 1'b1;
          end else if (!b_lead) begin
            add1 = b_member;
            emit = !b_member;
          end
        end
        PH_LEAD: begin
          add2 = !b_zero && pair_hit;
          emit = b_zero || !pair_hit;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  // span counter with saturation
  assign span_sum = {1'b0, span_cnt_r} + {{(COUNT_WIDTH-1){1'b0}}, add2, add1};

  always_comb begin
    span_cnt_nxt = span_cnt_r;
    sat_nxt      = sat_r;
    if (emit) begin
      span_cnt_nxt = '0;
      sat_nxt      = 1'b0;
    end else if (add1 || add2) begin
      if (span_sum[COUNT_WIDTH]) begin
        span_cnt_nxt = '1;
        sat_nxt      = 1'b1;
      end else begin
        span_cnt_nxt = span_sum[COUNT_WIDTH-1:0];
      end
    end
  end

  // result clamp to the output field
  assign len_clamp = ((span_cnt_r >> LEN_W) != '0);

  always_comb begin
    res.span_length      = len_clamp ? '1 : LEN_W'(span_cnt_r);
    res.length_saturated = sat_r || len_clamp;
    res.set_overflowed   = ovf_r;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_r    <= '0;
      pair_cnt_r  <= '0;
      ctl_pend_r  <= 1'b0;
      ctl_lead_r  <= '0;
      closed_r    <= 1'b0;
      ovf_r       <= 1'b0;
      phase_r     <= PH_SCAN;
      scan_lead_r <= '0;
      span_cnt_r  <= '0;
      sat_r       <= 1'b0;
    end else begin
      single_r    <= single_nxt;
      pair_cnt_r  <= pair_cnt_nxt;
      ctl_pend_r  <= ctl_pend_nxt;
      ctl_lead_r  <= ctl_lead_nxt;
      closed_r    <= closed_nxt;
      ovf_r       <= ovf_nxt;
      phase_r     <= phase_nxt;
      scan_lead_r <= scan_lead_nxt;
      span_cnt_r  <= span_cnt_nxt;
      sat_r       <= sat_nxt;
    end
  end

  // pair chain: a new pair enters cell 0, older pairs move one cell on
  assign chain_ctl.shift = insert;
  assign chain_ctl.probe = {scan_lead_r, b};
  assign chain_key[0]    = {ctl_lead_r, b};

  for (genvar g = 0; g < PAIR_DEPTH; g++) begin : g_cell
    dbcs_pair_cell u_cell (
      .clk     (clk),
      .ctl     (chain_ctl),
      .active  (PCNT_W'(g) < pair_cnt_r),
      .key_in  (chain_key[g]),
      .key_out (chain_key[g+1]),
      .hit     (cell_hit[g])
    );
  end

  // result queue
  dbcs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_data (res),
    .full      (fifo_full),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (out_res)
  );

  assign out_tdata = {6'd0, out_res.set_overflowed, out_res.length_saturated,
                      out_res.span_length};

endmodule

/* dv/dbcs_span_checker.sv */
// span checker for the dbcs character span scanner: follows the lead map, control set and
// scan state from the accepted items and compares every result item against its prediction
// depends on dbcs_pkg for the request codes, scan phases and the result layout
module dbcs_span_checker
  import dbcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          spans_owed,
  output int          items_seen,
  output int          spans_seen,
  output int          clamped_seen,
  output int          overflow_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAIR_SLOTS = 16;
  localparam int COUNT_MAX  = 65535;
  localparam logic [7:0] NUL_BYTE = 8'h00;

  // own copy of the configuration and the block state
  logic [63:0]      lead_map [4];
  logic [255:0]     members;
  logic [KEY_W-1:0] pair_keys [PAIR_SLOTS];
  int               pair_fill;
  logic             ctl_lead_pending;
  logic [7:0]       ctl_lead_byte;
  logic             set_closed;
  scan_phase_t      phase;
  logic [7:0]       scan_lead;
  int               span_bytes;
  logic             span_clamped;
  logic             pairs_dropped;
  result_t          spans_due [$];

  function automatic logic lead_byte(input logic [7:0] b);
    return lead_map[b[7:6]][b[5:0]];
  endfunction

  // parallel pair compare, only over the filled slots
  function automatic logic known_pair(input logic [7:0] lead, input logic [7:0] trail);
    for (int i = 0; i < pair_fill; i++) begin
      if (pair_keys[i] == {lead, trail}) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void grow_span(input int n);
    if (span_bytes + n > COUNT_MAX) begin
      span_bytes   = COUNT_MAX;
      span_clamped = 1'b1;
    end else begin
      span_bytes = span_bytes + n;
    end
  endfunction

  // span finished: queue the length and flags, restart the count
  function automatic void close_span();
    result_t r;
    r.span_length      = span_bytes[LEN_W-1:0];
    r.length_saturated = span_clamped;
    r.set_overflowed   = pairs_dropped;
    spans_due.push_back(r);
    span_bytes   = 0;
    span_clamped = 1'b0;
  endfunction

  function automatic void empty_set();
    members          = '0;
    pair_fill        = 0;
    ctl_lead_pending = 1'b0;
    ctl_lead_byte    = '0;
    set_closed       = 1'b0;
    pairs_dropped    = 1'b0;
    for (int i = 0; i < PAIR_SLOTS; i++) pair_keys[i] = '0;
  endfunction

  // control string byte: singles into the bitmap, lead/trail pairs into the table
  function automatic void take_control(input logic [7:0] b);
    if (set_closed) return;
    if (ctl_lead_pending) begin
      ctl_lead_pending = 1'b0;
      if (b == NUL_BYTE) begin
        set_closed = 1'b1;
      end else if (pair_fill < PAIR_SLOTS) begin
        pair_keys[pair_fill] = {ctl_lead_byte, b};
        pair_fill++;
      end else begin
        pairs_dropped = 1'b1;
      end
    end else if (b == NUL_BYTE) begin
      set_closed = 1'b1;
    end else if (lead_byte(b)) begin
      ctl_lead_pending = 1'b1;
      ctl_lead_byte    = b;
    end else begin
      members[b] = 1'b1;
    end
  endfunction

  // scanned string byte
  function automatic void take_scan(input logic [7:0] b);
    case (phase)
      PH_SCAN: begin
        if (b == NUL_BYTE) begin
          close_span();
        end else if (lead_byte(b)) begin
          scan_lead = b;
          phase     = PH_LEAD;
        end else if (members[b]) begin
          grow_span(1);
        end else begin
          phase = PH_SKIP;
          close_span();
        end
      end
      PH_LEAD: begin
        if (b == NUL_BYTE) begin
          phase = PH_SCAN;
          close_span();
        end else if (known_pair(scan_lead, b)) begin
          grow_span(2);
          phase = PH_SCAN;
        end else begin
          phase = PH_SKIP;
          close_span();
        end
      end
      default: begin
        if (b == NUL_BYTE) phase = PH_SCAN;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("span result %0d: %s is %0d, predicted %0d", spans_seen, what, got, want);
    mismatches++;
  endtask

  // watch all three channels at the rising edge
  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) lead_map[i] = '0;
      empty_set();
      phase        = PH_SCAN;
      scan_lead    = '0;
      span_bytes   = 0;
      span_clamped = 1'b0;
      spans_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) lead_map[cfg_index] = cfg_data;
      // results leave before this edge's item is predicted
      if (out_tvalid && out_tready) begin
        got = out_tdata[17:0];
        spans_seen++;
        if (got.length_saturated) clamped_seen++;
        if (got.set_overflowed) overflow_seen++;
        if (spans_due.size() == 0) begin
          report_mismatch("unexpected item, span_length", int'(got.span_length), -1);
        end else begin
          want = spans_due.pop_front();
          if (got.span_length != want.span_length)
            report_mismatch("span_length", int'(got.span_length), int'(want.span_length));
          if (got.length_saturated != want.length_saturated)
            report_mismatch("length_saturated", int'(got.length_saturated),
                            int'(want.length_saturated));
          if (got.set_overflowed != want.set_overflowed)
            report_mismatch("set_overflowed", int'(got.set_overflowed),
                            int'(want.set_overflowed));
        end
        if (out_tdata[23:18] != '0)
          report_mismatch("padding bits", int'(out_tdata[23:18]), 0);
      end
      if (in_tvalid && in_tready) begin
        items_seen++;
        case (in_tuser)
          REQ_CLEAR: empty_set();
          REQ_CTRL:  take_control(in_tdata);
          REQ_SCAN:  take_scan(in_tdata);
          default:   ;
        endcase
      end
    end
    spans_owed = spans_due.size();
  end

endmodule

/* dv/tb_top.sv */
// top of the dbcs character span scanner testbench: clock, reset, item stimulus, receiver
// stalls and the verdict; checking is done by dbcs_span_checker from dv/dbcs_span_checker.sv
// depends on dbcs_pkg and the scanner rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dbcs_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;   // unused request code, ignored by the block
  localparam logic [7:0] NUL_BYTE = 8'h00;
  localparam int HOLD_CYCLES   = 200;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int PHASE_ITEMS   = 100;
  localparam int SETTLE_CYCLES = 4;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] data_byte
  logic [1:0]  in_tuser   = '0;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [15:0] span_length, [16] length_saturated, [17] set_overflowed
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [63:0] cfg_data   = '0;

  int mismatches, spans_owed, items_seen, spans_seen, clamped_seen, overflow_seen;
  int cycle_count    = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_asks      = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int items_sent     = 0;

  // stimulus-side view of the lead map and the control set, used to shape strings
  logic [255:0] lead_cfg = '0;
  logic [7:0]   set_singles [$];
  logic [15:0]  set_pairs [$];

  always #2 clk = ~clk;

  dbcs_character_span_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  dbcs_span_checker span_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .spans_owed    (spans_owed),
    .items_seen    (items_seen),
    .spans_seen    (spans_seen),
    .clamped_seen  (clamped_seen),
    .overflow_seen (overflow_seen)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[dbcs_character_span_scanner] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus long hold-offs counted here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one item from a falling edge, return at the falling edge after acceptance
  task automatic send_item(input logic [1:0] req, input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (req != REQ_NONE) items_sent++;
  endtask

  // stop offering and wait for every predicted result
  task automatic drain();
    in_tvalid <= 1'b0;
    while (spans_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_lead_map(input logic [255:0] map);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data  <= map[64*i +: 64];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    lead_cfg = map;
  endtask

  // nonzero byte that is (or is not) a lead byte, zero if none was found
  function automatic logic [7:0] pick_byte(input logic want_lead);
    logic [7:0] b;
    for (int i = 0; i < 32; i++) begin
      b = 8'($urandom_range(1, 255));
      if (lead_cfg[b] == want_lead) return b;
    end
    return NUL_BYTE;
  endfunction

  function automatic logic [255:0] typical_map();
    logic [255:0] m;
    m = '0;
    for (int v = 8'h81; v <= 8'h9f; v++) m[v] = 1'b1;
    for (int v = 8'he0; v <= 8'hfc; v++) m[v] = 1'b1;
    return m;
  endfunction

  task automatic forget_set();
    set_singles.delete();
    set_pairs.delete();
  endtask

  // one character of the control set as scan items
  task automatic send_member(output int n_bytes);
    int pick;
    logic [15:0] key;
    n_bytes = 0;
    if (set_singles.size() + set_pairs.size() == 0) return;
    pick = $urandom_range(set_singles.size() + set_pairs.size() - 1);
    if (pick < set_singles.size()) begin
      send_item(REQ_SCAN, set_singles[pick]);
      n_bytes = 1;
    end else begin
      key = set_pairs[pick - set_singles.size()];
      send_item(REQ_SCAN, key[15:8]);
      send_item(REQ_SCAN, key[7:0]);
      n_bytes = 2;
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(9))
      0: begin
        send_item(REQ_CLEAR, 8'($urandom_range(255)));
        forget_set();
      end
      1, 2, 3: send_item(REQ_CTRL, 8'($urandom_range(255)));
      default: send_item(REQ_NONE, 8'($urandom_range(255)));
    endcase
  endtask

  task automatic scan_tail();
    repeat ($urandom_range(4)) send_item(REQ_SCAN, 8'($urandom_range(255)));
    send_item(REQ_SCAN, NUL_BYTE);
  endtask

  // one scanned string: mostly members, then a clean or broken ending
  task automatic scan_string();
    int len;
    int n;
    int ending;
    len = ($urandom_range(15) == 0) ? $urandom_range(60) : $urandom_range(10);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(11) == 0) send_noise();
      send_member(n);
    end
    ending = $urandom_range(19);
    if (ending < 11) begin
      send_item(REQ_SCAN, NUL_BYTE);
    end else if (ending < 14) begin
      send_item(REQ_SCAN, pick_byte(1'b0));
      scan_tail();
    end else if (ending < 16) begin
      // lead byte with a NUL trail
      send_item(REQ_SCAN, pick_byte(1'b1));
      send_item(REQ_SCAN, NUL_BYTE);
    end else if (ending < 18) begin
      send_item(REQ_SCAN, pick_byte(1'b1));
      send_item(REQ_SCAN, 8'($urandom_range(1, 255)));
      scan_tail();
    end else begin
      scan_tail();
    end
  endtask

  // optional stray items, usually a clear, control string, then a few strings; n_pairs below zero picks at random
  task automatic run_session(input int n_pairs);
    int n_single;
    int n_pair;
    int ending;
    logic [7:0] b;
    logic [7:0] t;
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 8)) send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
    end
    if ($urandom_range(9) != 0) begin
      send_item(REQ_CLEAR, 8'($urandom_range(255)));
      forget_set();
    end
    n_single = $urandom_range(6);
    n_pair   = (n_pairs >= 0) ? n_pairs : $urandom_range(5);
    while (n_single + n_pair > 0) begin
      if (n_pair > 0 && (n_single == 0 || $urandom_range(1) == 1)) begin
        b = pick_byte(1'b1);
        n_pair--;
        if (b != NUL_BYTE) begin
          t = 8'($urandom_range(1, 255));
          send_item(REQ_CTRL, b);
          send_item(REQ_CTRL, t);
          if (set_pairs.size() < 16) set_pairs.push_back({b, t});
        end
      end else begin
        b = pick_byte(1'b0);
        n_single--;
        if (b != NUL_BYTE) begin
          send_item(REQ_CTRL, b);
          set_singles.push_back(b);
        end
      end
    end
    // close with NUL, with a lead and NUL, or leave the set open
    ending = $urandom_range(19);
    if (ending < 16) begin
      send_item(REQ_CTRL, NUL_BYTE);
    end else if (ending < 18) begin
      b = pick_byte(1'b1);
      if (b != NUL_BYTE) send_item(REQ_CTRL, b);
      send_item(REQ_CTRL, NUL_BYTE);
    end
    repeat ($urandom_range(1, 4)) scan_string();
  endtask

  task automatic run_phase(input logic [255:0] map, input int gap_pct, input int stall_pct);
    int start;
    drain();
    load_lead_map(map);
    send_gap_pct = gap_pct;
    recv_stall_pct <= stall_pct;
    start = items_sent;
    run_session(16);
    run_session($urandom_range(17, 20));
    while (items_sent - start < PHASE_ITEMS) run_session(-1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    load_lead_map(typical_map());

    // directed: empty set, open set with a pending lead, closed set, broken pairs
    send_item(REQ_SCAN, NUL_BYTE);
    send_item(REQ_NONE, 8'hff);
    send_item(REQ_SCAN, 8'h41);
    send_item(REQ_SCAN, NUL_BYTE);
    send_item(REQ_CLEAR, 8'h00);
    send_item(REQ_CTRL, 8'h41);
    send_item(REQ_CTRL, 8'hff);
    send_item(REQ_CTRL, 8'h81);
    send_item(REQ_CTRL, 8'h40);
    send_item(REQ_CTRL, 8'h9f);
    send_item(REQ_SCAN, 8'h41);
    send_item(REQ_SCAN, 8'h81);
    send_item(REQ_SCAN, 8'h40);
    send_item(REQ_SCAN, 8'h9f);
    send_item(REQ_SCAN, NUL_BYTE);
    send_item(REQ_CTRL, NUL_BYTE);
    send_item(REQ_CTRL, 8'h42);
    send_item(REQ_SCAN, 8'h42);
    send_item(REQ_SCAN, 8'h41);
    send_item(REQ_SCAN, NUL_BYTE);
    send_item(REQ_SCAN, 8'hff);
    send_item(REQ_SCAN, 8'h81);
    send_item(REQ_SCAN, 8'h41);
    send_item(REQ_SCAN, NUL_BYTE);
    send_item(REQ_SCAN, NUL_BYTE);

    run_phase(typical_map(), 0, 0);

    // long receiver hold-off while the sender keeps offering
    drain();
    hold_asks <= hold_asks + 1;
    for (int i = 0; i < 30; i++) begin
      send_item(REQ_SCAN, ($urandom_range(1) == 1) ? NUL_BYTE : 8'($urandom_range(255)));
    end
    drain();

    run_phase('1, 68, 0);
    run_phase({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom},
              0, 68);
    run_phase('0, 21, 21);
    drain();

    $display("covered %0d items and %0d span results, %0d clamped, %0d after pair table overflow",
             items_seen, spans_seen, clamped_seen, overflow_seen);
    $display("lead maps: typical, all set, random, empty; idling mixes plus a long hold-off");
    if (mismatches == 0 && spans_owed == 0) begin
      $display("[dbcs_character_span_scanner] OK");
    end else begin
      $display("[dbcs_character_span_scanner] ERROR");
    end
    $finish;
  end

endmodule
